// File: src/pcsc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel color space converter package
// Conversion mode codes, pipeline sizes and the divider request type.
// ----------------------------------------------------------------------------
package pcsc_pkg;

    typedef enum logic [2:0] {
        MODE_GRAY2RGB = 3'd0,
        MODE_RGB2GRAY = 3'd1,
        MODE_YUV2RGB  = 3'd2,
        MODE_RGB2YUV  = 3'd3,
        MODE_RGB2HSL  = 3'd4,
        MODE_HSL2RGB  = 3'd5,
        MODE_RGB2HSV  = 3'd6,
        MODE_HSV2RGB  = 3'd7
    } t_mode;

    localparam int NUM_W        = 25;
    localparam int DEN_W        = 14;
    localparam int REM_W        = 22;
    localparam int QUO_W        = 8;
    localparam int DIV_STAGES   = QUO_W + 1;
    localparam int FRONT_STAGES = 4;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES;

    typedef struct packed {
        logic                    byp;
        logic [QUO_W-1:0]        bval;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_div_req;

endpackage

// File: src/pcsc_div_lane.sv
// ----------------------------------------------------------------------------
// Pipelined clamping divider lane
// Range check, then one restoring quotient bit per stage; result 0..255.
// ----------------------------------------------------------------------------
module pcsc_div_lane (
    input  logic                                i_clk,
    input  logic [pcsc_pkg::DIV_STAGES-1:0]     i_en,
    input  pcsc_pkg::t_div_req                  i_req,
    output logic [pcsc_pkg::QUO_W-1:0]          o_quo
);

    localparam int NST = pcsc_pkg::DIV_STAGES;
    localparam int RW  = pcsc_pkg::REM_W;
    localparam int QW  = pcsc_pkg::QUO_W;
    localparam int DW  = pcsc_pkg::DEN_W;
    localparam int NW  = pcsc_pkg::NUM_W;

    logic [RW-1:0] r_rem [NST];
    logic [DW-1:0] r_den [NST];
    logic [QW-1:0] r_quo [NST];
    logic          r_fix [NST];

    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic          n_fix;
    logic [NW-2:0] w_lim;

    always_comb begin
        w_lim = (NW-1)'(i_req.den) << QW;
        n_rem = i_req.num[RW-1:0];
        n_quo = '0;
        n_fix = 1'b1;
        if (i_req.byp) begin
            n_quo = i_req.bval;
        end else if (i_req.num[NW-1] || i_req.num == '0 || i_req.den == '0) begin
            n_quo = '0;
        end else if (i_req.num[NW-2:0] >= w_lim) begin
            n_quo = '1;
        end else begin
            n_fix = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= n_rem;
            r_den[0] <= i_req.den;
            r_quo[0] <= n_quo;
            r_fix[0] <= n_fix;
        end
    end

    genvar s;
    generate
        for (s = 1; s < NST; s++) begin : g_step
            localparam int QB = NST - 1 - s;
            logic [RW-1:0] w_ds;
            logic          w_take;
            assign w_ds   = RW'(r_den[s-1]) << QB;
            assign w_take = !r_fix[s-1] && (r_rem[s-1] >= w_ds);
            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_rem[s] <= w_take ? (r_rem[s-1] - w_ds) : r_rem[s-1];
                    r_den[s] <= r_den[s-1];
                    r_fix[s] <= r_fix[s-1];
                    r_quo[s] <= r_quo[s-1] | (w_take ? (QW'(1) << QB) : '0);
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[NST-1];

endmodule

// File: src/pixel_color_space_converter_core.sv
// ----------------------------------------------------------------------------
// Pixel color space converter core
// Structure: 4 arithmetic stages, then a 9-stage divider per output channel.
// Throughput: one item per cycle while the output accepts (i_ready high);
// each stage fills when empty, so bubbles close.
// Reset clears all stage valid bits and sets the mode to gray to RGB.
// ----------------------------------------------------------------------------
module pixel_color_space_converter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_chan_a,
    input  logic [7:0] i_chan_b,
    input  logic [7:0] i_chan_c,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_a,
    output logic [7:0] o_out_b,
    output logic [7:0] o_out_c,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);

    localparam int NS = pcsc_pkg::NUM_STAGES;
    localparam int FS = pcsc_pkg::FRONT_STAGES;

    pcsc_pkg::t_mode r_mode;
    logic [NS-1:0]   r_v;
    logic [NS-1:0]   en;

    function automatic pcsc_pkg::t_div_req f_byp(input logic [7:0] v);
        pcsc_pkg::t_div_req r;
        r      = '0;
        r.byp  = 1'b1;
        r.bval = v;
        return r;
    endfunction

    function automatic pcsc_pkg::t_div_req f_div(input logic signed [24:0] num,
                                                 input logic [13:0] den);
        pcsc_pkg::t_div_req r;
        r     = '0;
        r.num = num;
        r.den = den;
        return r;
    endfunction

    function automatic logic [8:0] f_wrap(input logic signed [10:0] t);
        logic signed [10:0] w;
        w = t;
        if (w < 0) w = w + 11'sd360;
        if (w > 11'sd360) w = w - 11'sd360;
        return w[8:0];
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pcsc_pkg::MODE_GRAY2RGB;
        end else if (i_cfg_valid) begin
            r_mode <= pcsc_pkg::t_mode'(i_cfg_data);
        end
    end

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: max, min, sector
    logic [7:0]  r0_a, r0_b, r0_c, r0_mx, r0_mn;
    logic [1:0]  r0_msel;
    logic [3:0]  r0_q60;
    logic [7:0]  n0_mx, n0_mn;
    logic [1:0]  n0_msel;
    logic [19:0] w0_prod;

    always_comb begin
        n0_mx = i_chan_a;
        n0_mn = i_chan_a;
        if (i_chan_b > n0_mx) n0_mx = i_chan_b;
        if (i_chan_c > n0_mx) n0_mx = i_chan_c;
        if (i_chan_b < n0_mn) n0_mn = i_chan_b;
        if (i_chan_c < n0_mn) n0_mn = i_chan_c;
        if (n0_mx == i_chan_a) n0_msel = 2'd0;
        else if (n0_mx == i_chan_b) n0_msel = 2'd1;
        else n0_msel = 2'd2;
        w0_prod = 20'(i_chan_a) * 20'd2186;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_a    <= i_chan_a;
            r0_b    <= i_chan_b;
            r0_c    <= i_chan_c;
            r0_mx   <= n0_mx;
            r0_mn   <= n0_mn;
            r0_msel <= n0_msel;
            r0_q60  <= w0_prod[19:16];
        end
    end

    // stage 1: linear sums, hue numerator, fraction, angles
    logic [7:0]         r1_a, r1_b, r1_c, r1_d, r1_mx;
    logic signed [24:0] r1_lin [3];
    logic signed [17:0] r1_hn;
    logic [8:0]         r1_sum;
    logic [5:0]         r1_fr;
    logic [2:0]         r1_sec;
    logic [15:0]        r1_cb;
    logic [8:0]         r1_t [3];

    logic signed [24:0] w1_a, w1_b, w1_c, w1_u, w1_v, w1_k, w1_d, w1_hn;
    logic signed [24:0] n1_lin [3];
    logic [8:0]         w1_fr;
    logic signed [10:0] w1_h;

    always_comb begin
        w1_a = $signed({17'b0, r0_a});
        w1_b = $signed({17'b0, r0_b});
        w1_c = $signed({17'b0, r0_c});
        w1_u = w1_b - 25'sd128;
        w1_v = w1_c - 25'sd128;
        w1_k = (w1_a - 25'sd16) * 25'sd1164;
        w1_d = $signed({17'b0, r0_mx - r0_mn});
        if (r_mode == pcsc_pkg::MODE_YUV2RGB) begin
            n1_lin[0] = w1_k + 25'sd1596 * w1_v;
            n1_lin[1] = w1_k - 25'sd813 * w1_v - 25'sd391 * w1_u;
            n1_lin[2] = w1_k + 25'sd2018 * w1_u;
        end else begin
            n1_lin[0] = 25'sd257 * w1_a + 25'sd504 * w1_b + 25'sd98 * w1_c + 25'sd16000;
            n1_lin[1] = 25'sd439 * w1_c - 25'sd148 * w1_a - 25'sd291 * w1_b + 25'sd128000;
            n1_lin[2] = 25'sd439 * w1_a - 25'sd368 * w1_b - 25'sd71 * w1_c + 25'sd128000;
        end
        case (r0_msel)
            2'd0:    w1_hn = 25'sd60 * (w1_b - w1_c);
            2'd1:    w1_hn = 25'sd60 * (w1_c - w1_a) + 25'sd120 * w1_d;
            default: w1_hn = 25'sd60 * (w1_a - w1_b) + 25'sd240 * w1_d;
        endcase
        w1_fr = {r0_a, 1'b0} - 9'(r0_q60 * 9'd60);
        w1_h  = $signed({2'b0, r0_a, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_a   <= r0_a;
            r1_b   <= r0_b;
            r1_c   <= r0_c;
            r1_d   <= r0_mx - r0_mn;
            r1_mx  <= r0_mx;
            r1_lin <= n1_lin;
            r1_hn  <= 18'(w1_hn);
            r1_sum <= 9'(r0_mx) + 9'(r0_mn);
            r1_fr  <= w1_fr[5:0];
            r1_sec <= (r0_q60 >= 4'd6) ? 3'(r0_q60 - 4'd6) : r0_q60[2:0];
            r1_cb  <= 16'(r0_c) * 16'(r0_b);
            r1_t[0] <= f_wrap(w1_h + 11'sd120);
            r1_t[1] <= f_wrap(w1_h);
            r1_t[2] <= f_wrap(w1_h - 11'sd120);
        end
    end

    // stage 2: hue wrap, saturation terms, p/q/t factors, HSL q and p
    logic [7:0]         r2_a, r2_b, r2_c, r2_l, r2_mx, r2_gray;
    logic signed [24:0] r2_lin [3];
    logic [16:0]        r2_hn;
    logic [8:0]         r2_d2, r2_satden;
    logic [15:0]        r2_satn, r2_pv;
    logic [13:0]        r2_frb, r2_nfrb;
    logic [2:0]         r2_sec;
    logic [16:0]        r2_qn, r2_pn, r2_dq;
    logic [1:0]         r2_rg [3];
    logic [5:0]         r2_m [3];

    logic signed [24:0] w2_hn;
    logic [16:0]        w2_qn, w2_c255;
    logic [8:0]         n2_satden;
    logic [1:0]         n2_rg [3];
    logic [5:0]         n2_m [3];

    always_comb begin
        w2_hn = 25'(r1_hn);
        if (r1_hn < 0) w2_hn = w2_hn + 25'sd360 * $signed({17'b0, r1_d});
        if (r_mode == pcsc_pkg::MODE_RGB2HSL) begin
            n2_satden = (r1_sum < 9'd255) ? r1_sum : 9'd510 - r1_sum;
        end else begin
            n2_satden = 9'(r1_mx);
        end
        w2_c255 = 17'(r1_c) * 17'd255;
        if (!r1_c[7]) w2_qn = w2_c255 + 17'(r1_cb);
        else w2_qn = w2_c255 + 17'(r1_b) * 17'd255 - 17'(r1_cb);
        for (int i = 0; i < 3; i++) begin
            n2_m[i] = '0;
            if (r1_t[i] < 9'd60) begin
                n2_rg[i] = 2'd0;
                n2_m[i]  = r1_t[i][5:0];
            end else if (r1_t[i] < 9'd180) begin
                n2_rg[i] = 2'd1;
            end else if (r1_t[i] < 9'd240) begin
                n2_rg[i] = 2'd2;
                n2_m[i]  = 6'(9'd240 - r1_t[i]);
            end else begin
                n2_rg[i] = 2'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_a      <= r1_a;
            r2_b      <= r1_b;
            r2_c      <= r1_c;
            r2_l      <= r1_sum[8:1];
            r2_mx     <= r1_mx;
            r2_gray   <= 8'({2'b0, r1_a[7:2]}) + 8'({1'b0, r1_b[7:1]}) + 8'({2'b0, r1_c[7:2]});
            r2_lin    <= r1_lin;
            r2_hn     <= w2_hn[16:0];
            r2_d2     <= {r1_d, 1'b0};
            r2_satn   <= 16'(r1_d) * 16'd255;
            r2_satden <= n2_satden;
            r2_pv     <= 16'(r1_c) * 16'(8'd255 - r1_b);
            r2_frb    <= 14'(r1_fr) * 14'(r1_b);
            r2_nfrb   <= 14'(6'd60 - r1_fr) * 14'(r1_b);
            r2_sec    <= r1_sec;
            r2_qn     <= w2_qn;
            r2_pn     <= 17'(r1_c) * 17'd510 - w2_qn;
            r2_dq     <= w2_qn - (17'(r1_c) * 17'd510 - w2_qn);
            r2_rg     <= n2_rg;
            r2_m      <= n2_m;
        end
    end

    // stage 3: divider requests per output channel
    pcsc_pkg::t_div_req r3_req [3];
    pcsc_pkg::t_div_req n3_req [3];
    pcsc_pkg::t_div_req w3_v, w3_p, w3_q, w3_t;
    pcsc_pkg::t_div_req w3_hsl [3];
    logic [21:0]        w3_qnum, w3_tnum;
    logic signed [24:0] w3_hnum;

    always_comb begin
        w3_qnum = 22'(r2_c) * 22'(14'd15300 - r2_frb);
        w3_tnum = 22'(r2_c) * 22'(14'd15300 - r2_nfrb);
        w3_v = f_byp(r2_c);
        w3_p = f_div($signed({9'b0, r2_pv}), 14'd255);
        w3_q = f_div($signed({3'b0, w3_qnum}), 14'd15300);
        w3_t = f_div($signed({3'b0, w3_tnum}), 14'd15300);
        for (int i = 0; i < 3; i++) begin
            w3_hnum = $signed({8'b0, r2_pn}) * 25'sd60
                    + $signed({8'b0, r2_dq}) * $signed({19'b0, r2_m[i]});
            case (r2_rg[i])
                2'd1:    w3_hsl[i] = f_div($signed({8'b0, r2_qn}), 14'd255);
                2'd3:    w3_hsl[i] = f_div($signed({8'b0, r2_pn}), 14'd255);
                default: w3_hsl[i] = f_div(w3_hnum, 14'd15300);
            endcase
        end
        unique case (r_mode)
            pcsc_pkg::MODE_GRAY2RGB: begin
                n3_req[0] = f_byp(r2_a);
                n3_req[1] = f_byp(r2_a);
                n3_req[2] = f_byp(r2_a);
            end
            pcsc_pkg::MODE_RGB2GRAY: begin
                n3_req[0] = f_byp(r2_gray);
                n3_req[1] = f_byp(8'd0);
                n3_req[2] = f_byp(8'd0);
            end
            pcsc_pkg::MODE_YUV2RGB, pcsc_pkg::MODE_RGB2YUV: begin
                n3_req[0] = f_div(r2_lin[0], 14'd1000);
                n3_req[1] = f_div(r2_lin[1], 14'd1000);
                n3_req[2] = f_div(r2_lin[2], 14'd1000);
            end
            pcsc_pkg::MODE_RGB2HSL: begin
                n3_req[0] = f_div($signed({8'b0, r2_hn}), 14'(r2_d2));
                n3_req[1] = f_div($signed({9'b0, r2_satn}), 14'(r2_satden));
                n3_req[2] = f_byp(r2_l);
            end
            pcsc_pkg::MODE_HSL2RGB: begin
                if (r2_b == 8'd0) begin
                    n3_req[0] = w3_v;
                    n3_req[1] = w3_v;
                    n3_req[2] = w3_v;
                end else begin
                    n3_req = w3_hsl;
                end
            end
            pcsc_pkg::MODE_RGB2HSV: begin
                n3_req[0] = f_div($signed({8'b0, r2_hn}), 14'(r2_d2));
                n3_req[1] = f_div($signed({9'b0, r2_satn}), 14'(r2_satden));
                n3_req[2] = f_byp(r2_mx);
            end
            pcsc_pkg::MODE_HSV2RGB: begin
                case (r2_sec)
                    3'd0: begin n3_req[0] = w3_v; n3_req[1] = w3_t; n3_req[2] = w3_p; end
                    3'd1: begin n3_req[0] = w3_q; n3_req[1] = w3_v; n3_req[2] = w3_p; end
                    3'd2: begin n3_req[0] = w3_p; n3_req[1] = w3_v; n3_req[2] = w3_t; end
                    3'd3: begin n3_req[0] = w3_p; n3_req[1] = w3_q; n3_req[2] = w3_v; end
                    3'd4: begin n3_req[0] = w3_t; n3_req[1] = w3_p; n3_req[2] = w3_v; end
                    default: begin
                        n3_req[0] = w3_v; n3_req[1] = w3_p; n3_req[2] = w3_q;
                    end
                endcase
            end
            default: begin
                n3_req[0] = f_byp(r2_a);
                n3_req[1] = f_byp(r2_a);
                n3_req[2] = f_byp(r2_a);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_req <= n3_req;
        end
    end

    pcsc_div_lane u_lane_a (
        .i_clk (i_clk),
        .i_en  (en[NS-1:FS]),
        .i_req (r3_req[0]),
        .o_quo (o_out_a)
    );

    pcsc_div_lane u_lane_b (
        .i_clk (i_clk),
        .i_en  (en[NS-1:FS]),
        .i_req (r3_req[1]),
        .o_quo (o_out_b)
    );

    pcsc_div_lane u_lane_c (
        .i_clk (i_clk),
        .i_en  (en[NS-1:FS]),
        .i_req (r3_req[2]),
        .o_quo (o_out_c)
    );

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v))
        else $error("input blocked while pipeline has an empty stage");

    a_gray_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode == pcsc_pkg::MODE_RGB2GRAY) |-> (o_out_b == 8'd0 && o_out_c == 8'd0))
        else $error("gray output carries nonzero second or third channel");

    a_gray_in_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode == pcsc_pkg::MODE_GRAY2RGB) |-> (o_out_a == o_out_b && o_out_b == o_out_c))
        else $error("gray to RGB channels differ");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_mode == pcsc_pkg::MODE_RGB2HSV || r_mode == pcsc_pkg::MODE_RGB2HSL))
        |-> (o_out_a < 8'd180))
        else $error("halved hue out of range");

endmodule
